// ===== src/sqte_pkg.sv =====
// shared constants, state codes and controller/datapath interface types
package sqte_pkg;

  // default store depth and fixed widths for the largest store
  localparam int unsigned MAX_LEN_DEF = 56;
  localparam int unsigned C_W         = 4;        // column and row counts up to 8
  localparam int unsigned SQ_W        = 2 * C_W;  // products of two counts
  localparam int unsigned POS_W       = 7;        // grid position incl. one step past
  localparam int unsigned TOT_W       = 7;        // result count of one run
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 1;

  // characters
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] NUL_CHAR   = 8'd0;

  // output modes
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_COMPACT = 2'd1;
  localparam logic [1:0] MODE_PADDED  = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_PADDED;

  // register address
  localparam logic [ADDR_W-1:0] ADDR_MODE = 1'b0;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQRT  = 5'b00010,
    S_SETUP = 5'b00100,
    S_STEP  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // take the accepted input item
    logic sqrt_inc;  // bump the column count
    logic setup;     // latch row count, run length, clear walk
    logic issue;     // read the current slot into the output register
    logic walk;      // move to the next grid slot
    logic count;     // one result delivered
    logic finish;    // run done, clear message state
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sqrt_done;  // column count squared covers the length
    logic skip;       // current slot gives no result
    logic last;       // current result closes the run
  } sts_t;

endpackage

// ===== src/sqte_ctrl.sv =====
// controller state machine for the square transposition encoder
module sqte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  input  sqte_pkg::sts_t    sts,
  output sqte_pkg::cmd_t    cmd
);

  sqte_pkg::state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      sqte_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_end_of_message) begin
            state_nxt = sqte_pkg::S_SQRT;
          end
        end
      end
      sqte_pkg::S_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = sqte_pkg::S_SETUP;
        end else begin
          cmd.sqrt_inc = 1'b1;
        end
      end
      sqte_pkg::S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sqte_pkg::S_STEP;
      end
      sqte_pkg::S_STEP: begin
        if (sts.skip) begin
          cmd.walk = 1'b1;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = sqte_pkg::S_EMIT;
        end
      end
      sqte_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.walk  = 1'b1;
          cmd.count = 1'b1;
          if (sts.last) begin
            cmd.finish = 1'b1;
            state_nxt  = sqte_pkg::S_IDLE;
          end else begin
            state_nxt = sqte_pkg::S_STEP;
          end
        end
      end
      default: begin
        state_nxt = sqte_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqte_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/sqte_dp.sv =====
// datapath: character store, square root, grid walk and output register
module sqte_dp #(
  parameter int unsigned MAX_LEN = sqte_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic [7:0]        in_char,
  input  logic              in_has_char,
  input  sqte_pkg::cmd_t    cmd,
  output sqte_pkg::sts_t    sts,
  output logic [7:0]        out_char,
  output logic              out_last,
  output logic              out_empty_res,
  output logic              out_overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  localparam int unsigned C_W   = sqte_pkg::C_W;
  localparam int unsigned SQ_W  = sqte_pkg::SQ_W;
  localparam int unsigned POS_W = sqte_pkg::POS_W;
  localparam int unsigned TOT_W = sqte_pkg::TOT_W;

  logic [7:0]       char_store_r [MAX_LEN];
  logic [CNT_W-1:0] cnt_r;
  logic             drop_r;
  logic [C_W-1:0]   c_r, r_r, row_r, col_r;
  logic [C_W-1:0]   row_nxt, col_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             gap_r, gap_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt, k_r;
  logic [7:0]       rd_r;
  logic             space_r;

  logic [7:0]       in_low;
  logic             in_keep;
  logic [POS_W-1:0] n_pos;
  logic [SQ_W-1:0]  n_sq, c_sq, c_cm1, grid, tot_pad;
  logic [C_W-1:0]   c_m1, row_inc, col_inc;
  logic             r_tall, mode_plain, mode_compact, empty;
  logic             slot_char, slot_space;

  // character filter
  always_comb begin
    in_low  = in_char;
    in_keep = 1'b0;
    if (in_char >= 8'h41 && in_char <= 8'h5a) begin
      in_low  = in_char | 8'h20;
      in_keep = 1'b1;
    end else if ((in_char >= 8'h61 && in_char <= 8'h7a) ||
                 (in_char >= 8'h30 && in_char <= 8'h39)) begin
      in_keep = 1'b1;
    end
  end

  // column and row counts
  assign n_pos  = POS_W'(cnt_r);
  assign n_sq   = SQ_W'(cnt_r);
  assign c_m1   = c_r - 1'b1;
  assign c_sq   = {{C_W{1'b0}}, c_r} * {{C_W{1'b0}}, c_r};
  assign c_cm1  = {{C_W{1'b0}}, c_r} * {{C_W{1'b0}}, c_m1};
  assign r_tall = c_cm1 < n_sq;
  assign grid   = r_tall ? c_sq : c_cm1;
  assign tot_pad = grid + SQ_W'(c_r) - 1'b1;

  assign mode_plain   = (mode == sqte_pkg::MODE_PLAIN);
  assign mode_compact = (mode == sqte_pkg::MODE_COMPACT);
  assign empty        = (cnt_r == '0);

  // run length
  always_comb begin
    if (empty) begin
      tot_nxt = TOT_W'(1);
    end else if (mode_plain || mode_compact) begin
      tot_nxt = TOT_W'(cnt_r);
    end else begin
      tot_nxt = tot_pad[TOT_W-1:0];
    end
  end

  // current slot kind
  always_comb begin
    slot_char  = 1'b0;
    slot_space = 1'b0;
    if (empty) begin
      slot_char = 1'b0;
    end else if (mode_plain) begin
      slot_char = 1'b1;
    end else if (gap_r) begin
      slot_space = 1'b1;
    end else if (pos_r < n_pos) begin
      slot_char = 1'b1;
    end else if (!mode_compact) begin
      slot_space = 1'b1;
    end
  end

  // grid walk: plain in order; else down column, padded gap space, next column
  assign row_inc = row_r + 1'b1;
  assign col_inc = col_r + 1'b1;
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    pos_nxt = pos_r;
    gap_nxt = gap_r;
    if (mode_plain) begin
      pos_nxt = pos_r + 1'b1;
    end else if (gap_r) begin
      gap_nxt = 1'b0;
      col_nxt = col_inc;
      row_nxt = '0;
      pos_nxt = POS_W'(col_inc);
    end else if (row_inc < r_r) begin
      row_nxt = row_inc;
      pos_nxt = pos_r + POS_W'(c_r);
    end else if (!mode_compact && col_inc < c_r) begin
      gap_nxt = 1'b1;
    end else begin
      col_nxt = col_inc;
      row_nxt = '0;
      pos_nxt = POS_W'(col_inc);
    end
  end

  // status
  assign sts.sqrt_done = c_sq >= n_sq;
  assign sts.skip      = !empty && !slot_char && !slot_space;
  assign sts.last      = (k_r == tot_r - 1'b1);

  // result fields
  assign out_char      = empty ? sqte_pkg::NUL_CHAR :
                         (space_r ? sqte_pkg::SPACE_CHAR : rd_r);
  assign out_last      = sts.last;
  assign out_empty_res = empty;
  assign out_overflow  = drop_r;

  // character store and read register
  always_ff @(posedge clk) begin
    if (cmd.load && in_has_char && in_keep && cnt_r < MAX_CNT) begin
      char_store_r[cnt_r[IDX_W-1:0]] <= in_low;
    end
    if (cmd.issue) begin
      space_r <= slot_space;
      if (slot_char) begin
        rd_r <= char_store_r[pos_r[IDX_W-1:0]];
      end
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      k_r    <= '0;
    end else begin
      if (cmd.load && in_has_char && in_keep) begin
        if (cnt_r < MAX_CNT) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.setup) begin
        k_r <= '0;
      end else if (cmd.count) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.finish) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  // square root, grid shape and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r <= '0;
    end else if (cmd.sqrt_inc) begin
      c_r <= c_r + 1'b1;
    end
    if (cmd.setup) begin
      r_r   <= r_tall ? c_r : c_m1;
      tot_r <= tot_nxt;
      row_r <= '0;
      col_r <= '0;
      pos_r <= '0;
      gap_r <= 1'b0;
    end else if (cmd.walk) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      pos_r <= pos_nxt;
      gap_r <= gap_nxt;
    end
  end

`ifndef SYNTHESIS
  // fill count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("stored count beyond store depth");

  // a store read only hits written entries
  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && slot_char) |-> (pos_r < n_pos))
    else $error("store read past stored count");

  // no result issued beyond the run length
  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (k_r < tot_r))
    else $error("result issued beyond run length");

  // message state is cleared after the closing result
  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (cnt_r == '0) && !drop_r)
    else $error("message state not cleared after run");
`endif

endmodule

// ===== src/square_transposition_encoder.sv =====
// top level: square transposition encoder with mode register port
// Accepted letters/digits are stored lower-cased; after the end item the column
// count steps up until its square covers the length; then the grid is set up.
// Throughput: 1 item per cycle while loading; each result is then read from the
// store into the output register and held until taken, and in compact mode any
// cells past the stored length are skipped. No item is taken during a run.
// Reset (synchronous, rst_n low): message cleared, output mode set to padded.
module square_transposition_encoder #(
  parameter int unsigned MAX_LEN = sqte_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char,
  input  logic                          in_has_char,
  input  logic                          in_end_of_message,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char,
  output logic                          out_last,
  output logic                          out_empty_res,
  output logic                          out_overflow,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqte_pkg::ADDR_W-1:0]   paddr,
  input  logic [sqte_pkg::DATA_W-1:0]   pwdata,
  output logic [sqte_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  sqte_pkg::cmd_t cmd;
  sqte_pkg::sts_t sts;
  logic [1:0]     mode_r;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sqte_pkg::MODE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == sqte_pkg::ADDR_MODE) begin
      mode_r <= pwdata[1:0];
    end
  end

  // register read back
  assign pready = 1'b1;
  assign prdata = (paddr == sqte_pkg::ADDR_MODE) ? sqte_pkg::DATA_W'(mode_r) : '0;

  // controller
  sqte_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sts               (sts),
    .cmd               (cmd)
  );

  // datapath
  sqte_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_char       (in_char),
    .in_has_char   (in_has_char),
    .cmd           (cmd),
    .sts           (sts),
    .out_char      (out_char),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_overflow  (out_overflow)
  );

endmodule
